// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, disabled while reset is asserted (active low).
`define CCP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccp assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define CCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccp assertion failed");

// Next-cycle implication that is checked during reset as well.
`define CCP_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ccp assertion failed");

`endif

// ===== hdl/ccp_pkg.sv =====
`timescale 1ns / 1ps

package ccp_pkg;

    localparam int COEFF_W         = 13;
    localparam int BYTE_W          = 8;
    localparam int ACC_W           = 12;
    localparam int CNT_W           = 4;
    localparam int T_W             = 5;
    // (u << 5) + MODULUS/2 stays below 2^19 for any 13-bit u
    localparam int X_W             = 19;
    localparam int MODULUS_DEFAULT = 3329;

    // compressed width select
    localparam logic MODE_D4 = 1'b0;
    localparam logic MODE_D5 = 1'b1;

    localparam logic [CNT_W-1:0] D_NARROW = CNT_W'(4);
    localparam logic [CNT_W-1:0] D_WIDE   = CNT_W'(5);
    localparam logic [T_W-1:0]   MASK_D4  = T_W'(15);
    localparam logic [T_W-1:0]   MASK_D5  = T_W'(31);

    typedef struct packed {
        logic signed [COEFF_W-1:0] coefficient;
        logic                      last_coeff;
    } t_coeff_item;

    typedef struct packed {
        logic [BYTE_W-1:0] packed_byte;
        logic              last_byte;
    } t_byte_item;

endpackage

// ===== hdl/coefficient_compress_pack.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// in        sink       i_in_valid / o_in_stall    i_in_data  (t_coeff_item)
// out       source     o_out_valid / i_out_stall  o_out_data (t_byte_item)
// cfg       sink       i_cfg_we                   i_cfg_wdata (coeff_bits_mode)
//
// One coefficient transfer per cycle is sustained unless output stalls back up; a result
// goes through the compress stage, then the pack stage into the output register.
// The compress stage holds the one multiplier (reciprocal of MODULUS); the pack
// stage holds the 12-bit accumulator and its bit count, the only loop-carried state.
// Reset is synchronous, active low, and clears mode, accumulator and valid bits.
// An output stall backs up into the compress stage and raises o_in_stall only
// when that stage is also full.
module coefficient_compress_pack
    import ccp_pkg::*;
#(
    parameter int MODULUS = MODULUS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    input  t_coeff_item i_in_data,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_byte_item  o_out_data,
    input  logic        i_out_stall
);

    // floor(x / MODULUS) == (x * RECIP) >> SHIFT exactly for every x < 2^X_W
    localparam int MOD_LOG = $clog2(MODULUS);
    localparam int SHIFT   = X_W + MOD_LOG;
    localparam int RECIP_W = X_W + 1;
    localparam int PROD_W  = X_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(MODULUS) - 64'd1) / 64'(MODULUS));
    localparam logic [COEFF_W-1:0] MOD_C  = COEFF_W'(MODULUS);
    localparam logic [X_W-1:0]     HALF_X = X_W'(MODULUS / 2);

    // configuration
    logic r_mode;

    // compress stage
    logic           r_s1_vld;
    logic [T_W-1:0] r_s1_t;
    logic           r_s1_last;
    logic           r_s1_wide;

    // pack state
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // output register
    logic       r_out_vld, n_out_vld;
    t_byte_item r_out_data, n_out_data;

    logic              in_xfer;
    logic              s1_adv;
    logic [COEFF_W-1:0] coeff_raw;
    logic [COEFF_W-1:0] u_val;
    logic [X_W-1:0]     x_val;
    logic [PROD_W-1:0]  prod;
    logic [T_W-1:0]     t_val;
    logic [ACC_W-1:0]   merged;
    logic [CNT_W-1:0]   cnt_sum;

    // the pack stage moves whenever the output register is empty or being drained
    assign s1_adv     = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_s1_vld && !s1_adv;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_D4;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // --- compress: map negatives up by MODULUS, then round((u << d) / MODULUS)
    always_comb begin
        coeff_raw = i_in_data.coefficient;
        u_val     = coeff_raw[COEFF_W-1] ? coeff_raw + MOD_C : coeff_raw;
        if (r_mode == MODE_D5) begin
            x_val = {1'b0, u_val, 5'b0} + HALF_X;
        end else begin
            x_val = {2'b0, u_val, 4'b0} + HALF_X;
        end
        prod  = PROD_W'(x_val) * PROD_W'(RECIP);
        t_val = prod[SHIFT +: T_W] & ((r_mode == MODE_D5) ? MASK_D5 : MASK_D4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_xfer) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_t    <= t_val;
            r_s1_last <= i_in_data.last_coeff;
            r_s1_wide <= (r_mode == MODE_D5);
        end
    end

    // --- pack: append LSB first, emit a byte at 8 bits or on the last coefficient
    always_comb begin
        merged     = r_acc | (ACC_W'(r_s1_t) << r_cnt);
        cnt_sum    = r_cnt + (r_s1_wide ? D_WIDE : D_NARROW);
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_out_vld  = r_out_vld && i_out_stall;
        n_out_data = r_out_data;
        if (s1_adv) begin
            n_out_data.packed_byte = merged[BYTE_W-1:0];
            n_out_data.last_byte   = r_s1_last;
            priority if (r_s1_last) begin
                // partial byte goes out as is; leftover bits are dropped
                n_out_vld = 1'b1;
                n_acc     = '0;
                n_cnt     = '0;
            end else if (cnt_sum >= CNT_W'(BYTE_W)) begin
                n_out_vld = 1'b1;
                n_acc     = merged >> BYTE_W;
                n_cnt     = cnt_sum - CNT_W'(BYTE_W);
            end else begin
                n_acc = merged;
                n_cnt = cnt_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_acc     <= n_acc;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

endmodule

// ===== hdl/ccp_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccp_checker
    import ccp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic        i_cfg_wdata,
    input logic        i_in_valid,
    input t_coeff_item i_in_data,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input t_byte_item  o_out_data,
    input logic        i_out_stall
);

    // a held result keeps its bits
    `CCP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // the input side only backs up behind a stalled output
    `CCP_ASSERT_IMPLY(a_stall_cause, i_clk, i_rst_n, o_in_stall, i_out_stall)

    // a last coefficient whose compress stage meets an unstalled output comes out as a last byte
    `CCP_ASSERT_NEXT(a_last_latency, i_clk, i_rst_n, (i_in_valid && !o_in_stall && i_in_data.last_coeff) ##1 !i_out_stall, o_out_valid && o_out_data.last_byte)

    // reset empties the output register
    `CCP_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind coefficient_compress_pack ccp_checker u_ccp_checker (.*);

// ===== tb/tb_coefficient_compress_pack.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the coefficient compressor / byte packer.
module tb_coefficient_compress_pack;
    import ccp_pkg::*;

    localparam int MOD         = MODULUS_DEFAULT;
    localparam int RESET_CYCLES = 10;
    // pipeline is two deep; the settle wait covers coefficients that emit nothing
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 10;
    localparam int IDLE_PCT      = 25;
    // far above the slowest legal run (~1.2k transfers with random gaps and stalls)
    localparam longint TIMEOUT_NS = 2_000_000;

    // ------------------------------------------------------------------
    // Expected-byte model: keeps its own mode, bit accumulator and count,
    // turns each accepted coefficient into zero or one expected byte and
    // checks every output transfer against the oldest one.
    // ------------------------------------------------------------------
    class packed_byte_model;
        logic             mode;
        logic [ACC_W-1:0] acc;
        logic [CNT_W-1:0] cnt;
        t_byte_item       expected_bytes[$];
        int               errors;

        function new();
            mode   = MODE_D4;
            acc    = '0;
            cnt    = '0;
            errors = 0;
        endfunction

        function void set_mode(logic m);
            mode = m;
        endfunction

        // round((u << d) / q) kept to d bits; negative inputs lifted by q first
        function logic [T_W-1:0] compress(logic [COEFF_W-1:0] raw);
            int unsigned      u;
            int unsigned      x;
            int unsigned      d;
            logic [T_W-1:0]   mask;
            d    = (mode == MODE_D5) ? D_WIDE : D_NARROW;
            mask = (mode == MODE_D5) ? MASK_D5 : MASK_D4;
            u    = raw;
            if (raw[COEFF_W-1]) u = (u + MOD) & 32'h1FFF;
            x = (u << d) + MOD / 2;
            return T_W'(x / MOD) & mask;
        endfunction

        function void note_coeff(t_coeff_item item);
            logic [T_W-1:0]   t;
            logic [CNT_W-1:0] d;
            t_byte_item       b;
            t   = compress(item.coefficient);
            d   = (mode == MODE_D5) ? D_WIDE : D_NARROW;
            acc = acc | (ACC_W'(t) << cnt);
            cnt = cnt + d;
            if (item.last_coeff) begin
                // partial byte goes out zero-padded; bits past one byte are dropped
                b.packed_byte = acc[BYTE_W-1:0];
                b.last_byte   = 1'b1;
                expected_bytes.push_back(b);
                acc = '0;
                cnt = '0;
            end else if (cnt >= CNT_W'(BYTE_W)) begin
                b.packed_byte = acc[BYTE_W-1:0];
                b.last_byte   = 1'b0;
                expected_bytes.push_back(b);
                acc = acc >> BYTE_W;
                cnt = cnt - CNT_W'(BYTE_W);
            end
        endfunction

        function void report(string what, int unsigned exp_v, int unsigned act_v);
            $display("%0t ns: %s mismatch, expected %0d actual %0d",
                     $time, what, exp_v, act_v);
            errors++;
        endfunction

        function void check_byte(t_byte_item got);
            t_byte_item want;
            if (expected_bytes.size() == 0) begin
                $display("%0t ns: unexpected byte transfer, expected none actual %0d/%0b",
                         $time, got.packed_byte, got.last_byte);
                errors++;
            end else begin
                want = expected_bytes.pop_front();
                if (got.packed_byte !== want.packed_byte)
                    report("packed_byte", want.packed_byte, got.packed_byte);
                if (got.last_byte !== want.last_byte)
                    report("last_byte", want.last_byte, got.last_byte);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, DUT hookup. Every input has a known value from time zero.
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        in_valid  = 1'b0;
    t_coeff_item in_data   = '0;
    logic        in_stall;
    logic        out_valid;
    t_byte_item  out_data;
    logic        out_stall = 1'b0;

    // no random gaps on either side while set
    logic        quiet     = 1'b0;

    packed_byte_model model = new();

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    coefficient_compress_pack #(
        .MODULUS (MOD)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    // Receiver: random stall about a quarter of the time, off during quiet stretch.
    always @(posedge clk) begin
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    // Transfer monitor. Samples pre-edge values, so it sees exactly what the
    // DUT saw at this edge. A coefficient never yields a byte on its own edge,
    // so checking before noting keeps the order straight.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) model.check_byte(out_data);
            if (in_valid && !in_stall) model.note_coeff(in_data);
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks. All called just after a rising edge; each step touches
    // in_valid with a single nonblocking assignment.
    // ------------------------------------------------------------------
    task automatic send_coeff(logic signed [COEFF_W-1:0] value, logic last);
        while (!quiet && ($urandom_range(99) < IDLE_PCT)) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid              <= 1'b1;
        in_data.coefficient   <= value;
        in_data.last_coeff    <= last;
        do @(posedge clk); while (in_stall);
    endtask

    // Sender holds off until every expected byte is out and the pipe is empty.
    // The first wait lets the monitor note the final coefficient.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (model.expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mode register; only called with the block drained.
    task automatic write_mode(logic m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        model.set_mode(m);
    endtask

    // Coefficient picker: mostly legal range, some right at a rounding step
    // (either sign), some raw 13-bit values from the whole 13-bit span.
    function automatic logic signed [COEFF_W-1:0] pick_coeff(logic m);
        int sel;
        int d;
        int k;
        int u;
        sel = $urandom_range(99);
        d   = (m == MODE_D5) ? D_WIDE : D_NARROW;
        if (sel < 75) begin
            return COEFF_W'($urandom_range(2 * (MOD - 1)) - (MOD - 1));
        end else if (sel < 88) begin
            k = $urandom_range(1, (1 << d));
            u = (k * MOD - MOD / 2 + (1 << d) - 1) >> d;
            u = u - $urandom_range(1);
            if (u >= MOD) u = MOD - 1;
            if (u > 0 && $urandom_range(1)) return COEFF_W'(u - MOD);
            return COEFF_W'(u);
        end else begin
            return COEFF_W'($urandom_range((1 << COEFF_W) - 1));
        end
    endfunction

    // Random polynomials, mostly short, now and then a full 256-coefficient
    // one. A few get a stray last flag early or lose the closing one.
    task automatic random_phase(int n_coeffs, logic m);
        int   sent;
        int   len;
        int   i;
        logic last;
        sent = 0;
        while (sent < n_coeffs) begin
            len = ($urandom_range(24) == 0) ? 256 : $urandom_range(1, 12);
            for (i = 0; i < len; i++) begin
                last = (i == len - 1);
                if ($urandom_range(29) == 0) last = !last;
                send_coeff(pick_coeff(m), last);
            end
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int   ph;
        logic m;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: 4-bit mode (reset value), range extremes, out-of-range,
        // and both sides of the first rounding step.
        write_mode(MODE_D4);
        send_coeff(0, 1'b0);
        send_coeff(3328, 1'b0);
        send_coeff(-3328, 1'b0);
        send_coeff(-1, 1'b0);
        send_coeff(1, 1'b0);
        send_coeff(4095, 1'b0);
        send_coeff(-4096, 1'b0);
        send_coeff(104, 1'b0);
        send_coeff(105, 1'b0);
        // nine nibbles in: four bits pending across the width switch
        drain();
        write_mode(MODE_D5);
        send_coeff(3328, 1'b0);
        send_coeff(-3328, 1'b0);
        send_coeff(52, 1'b0);
        send_coeff(53, 1'b1);
        // 5 + 5 + 5 + 5 = 20 bits: last arrives with more than a byte pending
        send_coeff(-1, 1'b0);
        send_coeff(1664, 1'b0);
        send_coeff(4095, 1'b0);
        send_coeff(-4096, 1'b1);
        // last with a partial byte in 5-bit mode
        send_coeff(2000, 1'b1);
        drain();
        write_mode(MODE_D4);
        // last exactly on a byte boundary, then a lone last nibble
        send_coeff(-3328, 1'b0);
        send_coeff(3328, 1'b1);
        send_coeff(-104, 1'b1);
        drain();

        // Random phases; the mode can change between phases, sometimes with
        // bits still pending. Phase 3 runs with no gaps on either side.
        for (ph = 0; ph < 8; ph++) begin
            m = (ph < 2) ? logic'(ph % 2 == 1) : logic'($urandom_range(1));
            quiet = (ph == 3);
            write_mode(m);
            random_phase(115, m);
            drain();
        end
        quiet = 1'b0;

        repeat (TAIL_CYCLES) @(posedge clk);
        if (model.expected_bytes.size() != 0)
            $display("%0t ns: bytes still outstanding, expected 0 actual %0d",
                     $time, model.expected_bytes.size());
        if (model.errors == 0 && model.expected_bytes.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ccp_pkg.sv
hdl/coefficient_compress_pack.sv
hdl/ccp_checker.sv
tb/tb_coefficient_compress_pack.sv
